// ===== rtl/ldr_pkg.sv =====
// Shared types and constants for the LED digit dirty-refresh block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none

package ldr_pkg;

  localparam int BUF_DEPTH   = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int DOT_BIT     = 7;

  // Request kinds as they arrive on req_type_i.
  localparam logic [2:0] REQ_SET_RAW = 3'd0;
  localparam logic [2:0] REQ_SET_DOT = 3'd1;
  localparam logic [2:0] REQ_CLEAR   = 3'd2;
  localparam logic [2:0] REQ_REFRESH = 3'd3;
  localparam logic [2:0] REQ_INIT    = 3'd4;

  // Driver register map and init values.
  localparam logic [3:0] ADDR_DECODE     = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY  = 4'hA;
  localparam logic [3:0] ADDR_SCAN_LIMIT = 4'hB;
  localparam logic [3:0] ADDR_POWER      = 4'hC;
  localparam int         DIGIT_ADDR_BASE = 9;
  localparam logic [7:0] INIT_INTENSITY  = 8'd4;
  localparam logic [7:0] POWER_ON        = 8'd1;
  localparam logic [7:0] DECODE_NONE     = 8'd0;

  // Init sequencer steps; digit blanking follows the fixed steps.
  localparam logic [3:0] INIT_STEP_DECODE    = 4'd0;
  localparam logic [3:0] INIT_STEP_SCAN      = 4'd1;
  localparam logic [3:0] INIT_STEP_INTENSITY = 4'd2;
  localparam logic [3:0] INIT_STEP_POWER     = 4'd3;
  localparam int         INIT_FIXED_STEPS    = 4;

  localparam logic [3:0] CFG_DIGITS_RESET = 4'd8;

  typedef enum logic [2:0] {
    CMD_SET_RAW,
    CMD_SET_DOT,
    CMD_CLEAR,
    CMD_REFRESH,
    CMD_INIT
  } cmd_kind_e;

  // Classified command passed from the front end to the engine.
  typedef struct packed {
    cmd_kind_e             kind;
    logic [2:0]            idx;    // buffer index for raw/dot
    logic [7:0]            value;  // raw byte, or dot value in bit 0
    logic [BUF_DEPTH-1:0]  mask;   // digits cleared or in use
    logic [3:0]            ndig;   // effective digit count
  } cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_REFRESH,
    ENG_INIT
  } eng_state_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } frame_t;

endpackage

`default_nettype wire

// ===== rtl/ldr_front.sv =====
// Front end: holds the digit count register, accepts and classifies requests.
// Depends on ldr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldr_front #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              busy_i,
  input  wire logic [2:0]        req_type_i,
  input  wire logic [2:0]        position_i,
  input  wire logic [7:0]        value_i,
  input  wire logic              dot_on_i,
  input  wire logic [3:0]        count_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [3:0]        cfg_data_i,
  output logic                   push_o,
  output ldr_pkg::cmd_t          cmd_o
);

  localparam logic [3:0] DigitCap = 4'(MAX_DIGITS);

  logic [3:0]                    digits_q;
  logic [3:0]                    ndig;
  logic [4:0]                    clear_end;
  logic [ldr_pkg::BUF_DEPTH-1:0] inuse_mask;
  logic [ldr_pkg::BUF_DEPTH-1:0] clear_mask;
  logic                          known;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= ldr_pkg::CFG_DIGITS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      digits_q <= cfg_data_i;
    end
  end

  // Saturate the digit count into 1..MAX_DIGITS.
  always_comb begin
    if (digits_q == 4'd0) begin
      ndig = 4'd1;
    end else if (digits_q > DigitCap) begin
      ndig = DigitCap;
    end else begin
      ndig = digits_q;
    end
  end

  assign clear_end = {2'b00, position_i} + {1'b0, count_i};

  always_comb begin
    for (int i = 0; i < ldr_pkg::BUF_DEPTH; i++) begin
      inuse_mask[i] = 4'(i) < ndig;
      clear_mask[i] = inuse_mask[i] && (5'(i) >= {2'b00, position_i}) && (5'(i) < clear_end);
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.ndig  = ndig;
    cmd_o.value = value_i;
    cmd_o.idx   = position_i;
    known       = 1'b1;
    case (req_type_i)
      ldr_pkg::REQ_SET_RAW: begin
        cmd_o.kind = ldr_pkg::CMD_SET_RAW;
        cmd_o.idx  = 3'(ldr_pkg::BUF_DEPTH - 1) - position_i;
      end
      ldr_pkg::REQ_SET_DOT: begin
        cmd_o.kind  = ldr_pkg::CMD_SET_DOT;
        cmd_o.value = {7'd0, dot_on_i};
      end
      ldr_pkg::REQ_CLEAR: begin
        cmd_o.kind = ldr_pkg::CMD_CLEAR;
        cmd_o.mask = clear_mask;
      end
      ldr_pkg::REQ_REFRESH: begin
        cmd_o.kind = ldr_pkg::CMD_REFRESH;
        cmd_o.mask = inuse_mask;
      end
      ldr_pkg::REQ_INIT: begin
        cmd_o.kind = ldr_pkg::CMD_INIT;
        cmd_o.mask = inuse_mask;
      end
      default: begin
        // drop unknown kinds
        known = 1'b0;
      end
    endcase
  end

  assign push_o = start && !busy_i && known;

endmodule

`default_nettype wire

// ===== rtl/ldr_cmd_fifo.sv =====
// Short command queue between the front end and the engine.
// Depends on ldr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ldr_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ldr_pkg::cmd_t wdata_i,
  input  wire logic          pop_i,
  output ldr_pkg::cmd_t      rdata_o,
  output logic               empty_o,
  output logic               full_o
);

  localparam int PtrW = $clog2(ldr_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(ldr_pkg::QUEUE_DEPTH + 1);

  ldr_pkg::cmd_t   entry_q [ldr_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CntW'(ldr_pkg::QUEUE_DEPTH);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ldr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ldr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ldr_engine.sv =====
// Engine: digit buffer, shown copy, refresh walker and init sequencer.
// Depends on ldr_pkg; fed by ldr_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ldr_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire ldr_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               result_strobe_o,
  output logic [3:0]         reg_addr_o,
  output logic [7:0]         reg_data_o,
  output logic               last_o
);

  localparam int Depth = ldr_pkg::BUF_DEPTH;

  ldr_pkg::eng_state_e state_q, state_d;
  logic [3:0]          step_q, step_d;
  logic [Depth-1:0]    dirty_q, dirty_d;
  logic [3:0]          ndig_q, ndig_d;
  logic [7:0]          digit_q [Depth];
  logic [7:0]          shown_q [Depth];
  ldr_pkg::frame_t     frame_q, frame_d;

  logic [Depth-1:0]    diff_mask;
  logic [Depth-1:0]    step_sel;
  logic [Depth-1:0]    rest_mask;
  logic [3:0]          init_last_step;
  logic                take;

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      diff_mask[i] = digit_q[i] != shown_q[i];
    end
  end

  assign step_sel       = Depth'(1) << step_q[2:0];
  assign rest_mask      = dirty_q & ~step_sel;
  assign init_last_step = 4'(ldr_pkg::INIT_FIXED_STEPS - 1) + ndig_q;
  assign take           = (state_q == ldr_pkg::ENG_IDLE) && cmd_valid_i;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dirty_d = dirty_q;
    ndig_d  = ndig_q;
    case (state_q)
      ldr_pkg::ENG_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            ldr_pkg::CMD_REFRESH: begin
              dirty_d = diff_mask & cmd_i.mask;
              step_d  = '0;
              if ((diff_mask & cmd_i.mask) != '0) begin
                state_d = ldr_pkg::ENG_REFRESH;
              end
            end
            ldr_pkg::CMD_INIT: begin
              state_d = ldr_pkg::ENG_INIT;
              step_d  = '0;
              ndig_d  = cmd_i.ndig;
            end
            default: begin
            end
          endcase
        end
      end
      ldr_pkg::ENG_REFRESH: begin
        step_d  = step_q + 4'd1;
        dirty_d = rest_mask;
        if (rest_mask == '0) begin
          state_d = ldr_pkg::ENG_IDLE;
        end
      end
      ldr_pkg::ENG_INIT: begin
        step_d = step_q + 4'd1;
        if (step_q == init_last_step) begin
          state_d = ldr_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_d = ldr_pkg::ENG_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    frame_d   = '0;
    cmd_pop_o = 1'b0;
    case (state_q)
      ldr_pkg::ENG_IDLE: begin
        cmd_pop_o = cmd_valid_i;
      end
      ldr_pkg::ENG_REFRESH: begin
        frame_d.valid = dirty_q[step_q[2:0]];
        frame_d.addr  = 4'(ldr_pkg::DIGIT_ADDR_BASE - 1) - step_q;
        frame_d.data  = digit_q[step_q[2:0]];
        frame_d.last  = rest_mask == '0;
      end
      ldr_pkg::ENG_INIT: begin
        frame_d.valid = 1'b1;
        frame_d.last  = step_q == init_last_step;
        case (step_q)
          ldr_pkg::INIT_STEP_DECODE: begin
            frame_d.addr = ldr_pkg::ADDR_DECODE;
            frame_d.data = ldr_pkg::DECODE_NONE;
          end
          ldr_pkg::INIT_STEP_SCAN: begin
            frame_d.addr = ldr_pkg::ADDR_SCAN_LIMIT;
            frame_d.data = {4'd0, ndig_q - 4'd1};
          end
          ldr_pkg::INIT_STEP_INTENSITY: begin
            frame_d.addr = ldr_pkg::ADDR_INTENSITY;
            frame_d.data = ldr_pkg::INIT_INTENSITY;
          end
          ldr_pkg::INIT_STEP_POWER: begin
            frame_d.addr = ldr_pkg::ADDR_POWER;
            frame_d.data = ldr_pkg::POWER_ON;
          end
          default: begin
            // blank digit registers 1..n
            frame_d.addr = step_q - 4'(ldr_pkg::INIT_FIXED_STEPS - 1);
            frame_d.data = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ldr_pkg::ENG_IDLE;
      step_q  <= '0;
      dirty_q <= '0;
      ndig_q  <= ldr_pkg::CFG_DIGITS_RESET;
      frame_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dirty_q <= dirty_d;
      ndig_q  <= ndig_d;
      frame_q <= frame_d;
    end
  end

  // Buffer edits land only while idle, so the walkers see stable bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        digit_q[i] <= '0;
        shown_q[i] <= '0;
      end
    end else if (take) begin
      case (cmd_i.kind)
        ldr_pkg::CMD_SET_RAW: begin
          digit_q[cmd_i.idx] <= cmd_i.value;
        end
        ldr_pkg::CMD_SET_DOT: begin
          digit_q[cmd_i.idx][ldr_pkg::DOT_BIT] <= cmd_i.value[0];
        end
        ldr_pkg::CMD_CLEAR, ldr_pkg::CMD_INIT: begin
          for (int i = 0; i < Depth; i++) begin
            if (cmd_i.mask[i]) begin
              digit_q[i] <= '0;
            end
          end
        end
        ldr_pkg::CMD_REFRESH: begin
          for (int i = 0; i < Depth; i++) begin
            if (cmd_i.mask[i]) begin
              shown_q[i] <= digit_q[i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_strobe_o = frame_q.valid;
  assign reg_addr_o      = frame_q.addr;
  assign reg_data_o      = frame_q.data;
  assign last_o          = frame_q.last;

  a_frame_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.valid |-> $past(state_q) != ldr_pkg::ENG_IDLE)
    else $error("frame without an active walk");

  a_refresh_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ldr_pkg::ENG_REFRESH |-> dirty_q != '0)
    else $error("refresh walk with no dirty digit");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.valid && frame_q.last |-> state_q == ldr_pkg::ENG_IDLE)
    else $error("last frame while run continues");

  a_init_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ldr_pkg::ENG_INIT |-> step_q <= init_last_step)
    else $error("init step past digit count");

endmodule

`default_nettype wire

// ===== rtl/led_digit_dirty_refresh_top.sv =====
// LED digit driver with dirty refresh. The idle engine applies edit items;
// refresh walks from digit 0 to the last changed digit and sends a frame only
// for changed digits; init sends four fixed writes, then blanks each used digit.
// Frames register in the cycle after each walker step; a two-entry queue keeps
// start open while the engine works. Reset zeroes both buffers, digit count 8.
`timescale 1ns / 1ps
`default_nettype none

module led_digit_dirty_refresh_top #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] req_type_i,
  input  wire logic [2:0] position_i,
  input  wire logic [7:0] value_i,
  input  wire logic       dot_on_i,
  input  wire logic [3:0] count_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [3:0] cfg_data_i,
  output logic            result_strobe_o,
  output logic [3:0]      reg_addr_o,
  output logic [7:0]      reg_data_o,
  output logic            last_o
);

  ldr_pkg::cmd_t front_cmd;
  ldr_pkg::cmd_t queue_cmd;
  logic          push;
  logic          pop;
  logic          queue_empty;
  logic          queue_full;

  assign busy = queue_full;

  ldr_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy_i      (queue_full),
    .req_type_i  (req_type_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .dot_on_i    (dot_on_i),
    .count_i     (count_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  ldr_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (pop),
    .rdata_o (queue_cmd),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  ldr_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (!queue_empty),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (pop),
    .result_strobe_o (result_strobe_o),
    .reg_addr_o      (reg_addr_o),
    .reg_data_o      (reg_data_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_led_digit_dirty_refresh_top.sv =====
// Self-checking testbench for led_digit_dirty_refresh_top: directed and random requests,
// with an internal predictor of the digit buffer, the sent copy and the frame stream.
// Depends on ldr_pkg (rtl/ldr_pkg.sv) and the top-level RTL.
`timescale 1ns / 1ps

module tb_led_digit_dirty_refresh_top;

  localparam int DIGIT_CAP          = 8;
  localparam int REQ_KIND_SPAN      = 8;
  localparam int DRAIN_CYCLES       = 48;
  localparam int RANDOM_PHASE_ITEMS = 64;
  localparam int IDLE_PCT           = 27;
  localparam time TIMEOUT_NS        = 2_000_000;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] pos;
    logic [7:0] val;
    logic       dot;
    logic [3:0] cnt;
  } disp_req_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } write_frame_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  logic [2:0] req_type_i  = '0;
  logic [2:0] position_i  = '0;
  logic [7:0] value_i     = '0;
  logic       dot_on_i    = 1'b0;
  logic [3:0] count_i     = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i  = '0;
  logic       result_strobe_o;
  logic [3:0] reg_addr_o;
  logic [7:0] reg_data_o;
  logic       last_o;

  led_digit_dirty_refresh_top #(.MAX_DIGITS(DIGIT_CAP)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .dot_on_i       (dot_on_i),
    .count_i        (count_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_strobe_o(result_strobe_o),
    .reg_addr_o     (reg_addr_o),
    .reg_data_o     (reg_data_o),
    .last_o         (last_o)
  );

  // Predicted display state
  logic [7:0] seg_buf   [ldr_pkg::BUF_DEPTH];
  logic [7:0] sent_copy [ldr_pkg::BUF_DEPTH];
  logic [3:0] digit_cfg = ldr_pkg::CFG_DIGITS_RESET;

  disp_req_t    pending_reqs [$];
  write_frame_t frames_due   [$];
  disp_req_t    cur_req;
  write_frame_t got_frame;
  write_frame_t want_frame;

  int submitted_count = 0;
  int accepted_count  = 0;
  int frames_checked  = 0;
  int cfg_writes      = 0;
  int error_count     = 0;
  int idle_pct        = IDLE_PCT;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_led_digit_dirty_refresh_top: done, errors");
    $finish;
  end

  function automatic int shown_digits();
    if (digit_cfg == 0) return 1;
    if (digit_cfg > DIGIT_CAP) return DIGIT_CAP;
    return digit_cfg;
  endfunction

  function automatic void push_frame(int addr, int data);
    write_frame_t f;
    f.addr = 4'(addr);
    f.data = 8'(data);
    f.last = 1'b0;
    frames_due.push_back(f);
  endfunction

  // Update the display state for one accepted request and queue its frames.
  function automatic void apply_request(disp_req_t r);
    int n;
    int i;
    int stop;
    int first;
    write_frame_t tail;
    n = shown_digits();
    first = frames_due.size();
    case (r.kind)
      ldr_pkg::REQ_SET_RAW: seg_buf[3'd7 - r.pos] = r.val;
      ldr_pkg::REQ_SET_DOT: seg_buf[r.pos][ldr_pkg::DOT_BIT] = r.dot;
      ldr_pkg::REQ_CLEAR: begin
        stop = int'(r.pos) + int'(r.cnt);
        if (stop > n) stop = n;
        for (i = r.pos; i < stop; i++) seg_buf[i] = '0;
      end
      ldr_pkg::REQ_REFRESH: begin
        for (i = 0; i < n; i++) begin
          if (seg_buf[i] != sent_copy[i])
            push_frame(ldr_pkg::DIGIT_ADDR_BASE - (i + 1), seg_buf[i]);
          sent_copy[i] = seg_buf[i];
        end
      end
      ldr_pkg::REQ_INIT: begin
        push_frame(ldr_pkg::ADDR_DECODE, ldr_pkg::DECODE_NONE);
        push_frame(ldr_pkg::ADDR_SCAN_LIMIT, n - 1);
        push_frame(ldr_pkg::ADDR_INTENSITY, ldr_pkg::INIT_INTENSITY);
        push_frame(ldr_pkg::ADDR_POWER, ldr_pkg::POWER_ON);
        for (i = 0; i < n; i++) begin
          seg_buf[i] = '0;
          push_frame(i + 1, 0);
        end
      end
      default: ;
    endcase
    if (frames_due.size() > first) begin
      tail = frames_due.pop_back();
      tail.last = 1'b1;
      frames_due.push_back(tail);
    end
  endfunction

  // Driver: hold the item until the edge that accepts it, then maybe idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(cur_req);
        accepted_count++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_reqs.pop_front();
          start      <= 1'b1;
          req_type_i <= cur_req.kind;
          position_i <= cur_req.pos;
          value_i    <= cur_req.val;
          dot_on_i   <= cur_req.dot;
          count_i    <= cur_req.cnt;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed frame must match the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      got_frame.addr = reg_addr_o;
      got_frame.data = reg_data_o;
      got_frame.last = last_o;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: reg_addr %0h reg_data %0h last %0b",
               reg_addr_o, reg_data_o, last_o);
        error_count++;
      end else begin
        want_frame = frames_due.pop_front();
        if (got_frame.addr !== want_frame.addr) begin
          $error("reg_addr: expected %0h, got %0h", want_frame.addr, got_frame.addr);
          error_count++;
        end
        if (got_frame.data !== want_frame.data) begin
          $error("reg_data: expected %0h, got %0h", want_frame.data, got_frame.data);
          error_count++;
        end
        if (got_frame.last !== want_frame.last) begin
          $error("last: expected %0b, got %0b", want_frame.last, got_frame.last);
          error_count++;
        end
      end
      frames_checked++;
    end
  end

  task automatic queue_req(input logic [2:0] kind, input logic [2:0] pos,
                           input logic [7:0] val, input logic dot, input logic [3:0] cnt);
    disp_req_t r;
    r.kind = kind;
    r.pos  = pos;
    r.val  = val;
    r.dot  = dot;
    r.cnt  = cnt;
    pending_reqs.push_back(r);
    submitted_count++;
  endtask

  // Wait until every item is taken and every frame seen, then let the engine drain.
  task automatic settle();
    while (accepted_count != submitted_count || frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_digit_count(input logic [3:0] setting);
    settle();
    cfg_data_i  <= setting;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    digit_cfg = setting;
    cfg_writes++;
  endtask

  task automatic queue_random(input int items);
    int j;
    int roll;
    logic [2:0] kind;
    logic [7:0] val;
    logic [3:0] cnt;
    for (j = 0; j < items; j++) begin
      roll = $urandom_range(99);
      if (roll < 28) kind = ldr_pkg::REQ_SET_RAW;
      else if (roll < 46) kind = ldr_pkg::REQ_SET_DOT;
      else if (roll < 58) kind = ldr_pkg::REQ_CLEAR;
      else if (roll < 84) kind = ldr_pkg::REQ_REFRESH;
      else if (roll < 92) kind = ldr_pkg::REQ_INIT;
      else kind = 3'($urandom_range(REQ_KIND_SPAN - 1, ldr_pkg::REQ_INIT + 1));
      if ($urandom_range(3) == 0) val = $urandom_range(1) ? 8'hFF : 8'h00;
      else val = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) cnt = 4'($urandom_range(15));
      else cnt = 4'($urandom_range(DIGIT_CAP));
      queue_req(kind, 3'($urandom_range(7)), val, 1'($urandom_range(1)), cnt);
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < ldr_pkg::BUF_DEPTH; k++) begin
      seg_buf[k]   = '0;
      sent_copy[k] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full digit count from reset
    queue_req(ldr_pkg::REQ_INIT,    3'd0, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);  // nothing changed
    queue_req(ldr_pkg::REQ_SET_RAW, 3'd0, 8'hFF, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_SET_RAW, 3'd7, 8'h7E, 1'b1, 4'd0);
    queue_req(ldr_pkg::REQ_SET_DOT, 3'd0, 8'h00, 1'b1, 4'd0);
    queue_req(ldr_pkg::REQ_SET_DOT, 3'd7, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_CLEAR,   3'd2, 8'h00, 1'b0, 4'd0);  // zero count
    queue_req(ldr_pkg::REQ_CLEAR,   3'd6, 8'h00, 1'b0, 4'd8);  // runs past the digit count
    queue_req(ldr_pkg::REQ_CLEAR,   3'd7, 8'hFF, 1'b1, 4'd15);
    for (k = ldr_pkg::REQ_INIT + 1; k < REQ_KIND_SPAN; k++)
      queue_req(3'(k), 3'd3, 8'hA5, 1'b1, 4'd5);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);

    // Short display: edits beyond the count must never be sent
    set_digit_count(4'd3);
    queue_req(ldr_pkg::REQ_SET_RAW, 3'd0, 8'hA5, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_CLEAR,   3'd5, 8'h00, 1'b0, 4'd2);  // start beyond the count
    queue_req(ldr_pkg::REQ_SET_RAW, 3'd5, 8'h3C, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_INIT,    3'd0, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);

    // Zero count saturates to one digit
    set_digit_count(4'd0);
    queue_req(ldr_pkg::REQ_INIT,    3'd0, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_SET_DOT, 3'd0, 8'h00, 1'b1, 4'd0);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);

    // Oversized count saturates to the full display
    set_digit_count(4'd15);
    queue_req(ldr_pkg::REQ_REFRESH, 3'd0, 8'h00, 1'b0, 4'd0);
    queue_req(ldr_pkg::REQ_INIT,    3'd0, 8'h00, 1'b0, 4'd0);

    set_digit_count(4'd1);
    queue_random(RANDOM_PHASE_ITEMS);
    set_digit_count(4'd8);
    idle_pct = 0;  // back-to-back stretch
    queue_random(RANDOM_PHASE_ITEMS);
    settle();
    idle_pct = IDLE_PCT;
    set_digit_count(4'($urandom_range(15)));
    queue_random(RANDOM_PHASE_ITEMS);
    set_digit_count(4'd2);
    queue_random(RANDOM_PHASE_ITEMS);
    set_digit_count(4'd12);
    queue_random(RANDOM_PHASE_ITEMS);
    set_digit_count(4'($urandom_range(1, 7)));
    queue_random(RANDOM_PHASE_ITEMS);
    settle();

    $display("tb: %0d requests accepted, %0d write frames checked",
             accepted_count, frames_checked);
    $display("tb: %0d digit-count writes, saturated and in-range settings included",
             cfg_writes);
    if (error_count == 0) begin
      $display("tb_led_digit_dirty_refresh_top: done, clean");
    end else begin
      $display("tb_led_digit_dirty_refresh_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ldr_pkg.sv
rtl/ldr_front.sv
rtl/ldr_cmd_fifo.sv
rtl/ldr_engine.sv
rtl/led_digit_dirty_refresh_top.sv
tb/sv/tb_led_digit_dirty_refresh_top.sv
